/* rtl/core/double_ended_queue_assert.svh */
// assertion macros for the double-ended queue
// used by dq_ctrl and dq_dpath; no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define DQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/core/dq_pkg.sv */
// shared types and constants for the double-ended queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int DATA_W = 32;
  localparam int REQ_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } stat_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/core/dq_in_if.sv */
// request channel of the double-ended queue
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none
interface dq_in_if;
  logic valid;
  logic ready;
  logic [dq_pkg::REQ_W-1:0] req_type;
  logic signed [dq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/dq_out_if.sv */
// result channel of the double-ended queue
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none
interface dq_out_if #(
  parameter int CNT_W = $clog2(dq_pkg::DEPTH_DEF + 1)
);
  logic valid;
  logic ready;
  logic signed [dq_pkg::DATA_W-1:0] pop_value;
  logic [dq_pkg::STAT_W-1:0] status;
  logic [CNT_W-1:0] entries;

  modport source (output valid, output pop_value, output status, output entries,
                  input ready);
  modport sink (input valid, input pop_value, input status, input entries,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/dq_ctrl.sv */
// controller of the double-ended queue: sequences latch, execute and result beat
// depends on dq_pkg and double_ended_queue_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_assert.svh"
module dq_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output dq_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.latch = in_ready && in_valid;
  assign cmd.exec  = (state_r == S_EXEC);

  `DQ_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "request and result overlap")
  `DQ_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, cmd.exec, "accepted beat not executed")
endmodule
`default_nettype wire

/* rtl/core/dq_dpath.sv */
// datapath of the double-ended queue: ring store, front pointer, count, result registers
// depends on dq_pkg and double_ended_queue_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_assert.svh"
module dq_dpath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::cmd_t                     cmd,
  input  logic [dq_pkg::REQ_W-1:0]         req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value,
  output logic signed [dq_pkg::DATA_W-1:0] pop_value,
  output logic [dq_pkg::STAT_W-1:0]        status,
  output logic [CNT_W-1:0]                 entries
);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dq_pkg::DATA_W-1:0] rd_r;
  dq_pkg::req_t              req_r;
  logic [dq_pkg::DATA_W-1:0] val_r;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  dq_pkg::stat_t             stat_r, stat_nxt;
  logic                      pop_ok_r, pop_ok_nxt;

  logic             is_push, full, empty;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [IDX_W-1:0] front_dec, front_inc, rear_push, rear_pop;
  logic [SUM_W-1:0] sum_push, sum_pop, sum_inc;

  assign is_push = req_r inside {dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_REAR};
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);

  // ring index arithmetic, sums stay below twice the depth
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign sum_inc   = SUM_W'(front_r) + 1'b1;
  assign front_inc = (sum_inc >= DEPTH_S) ? IDX_W'(sum_inc - DEPTH_S) : IDX_W'(sum_inc);
  assign sum_push  = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign rear_push = (sum_push >= DEPTH_S) ? IDX_W'(sum_push - DEPTH_S) : IDX_W'(sum_push);
  assign sum_pop   = sum_push - 1'b1;
  assign rear_pop  = (sum_pop >= DEPTH_S) ? IDX_W'(sum_pop - DEPTH_S) : IDX_W'(sum_pop);

  always_comb begin
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    stat_nxt   = dq_pkg::ST_OK;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = rear_push;
    rd_addr    = front_r;
    if (is_push && full) begin
      stat_nxt = dq_pkg::ST_OVERFLOW;
    end else if (!is_push && empty) begin
      stat_nxt = dq_pkg::ST_UNDERFLOW;
    end else begin
      case (req_r)
        dq_pkg::REQ_PUSH_FRONT: begin
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + 1'b1;
        end
        dq_pkg::REQ_PUSH_REAR: begin
          wr_en   = 1'b1;
          wr_addr = rear_push;
          cnt_nxt = cnt_r + 1'b1;
        end
        dq_pkg::REQ_POP_FRONT: begin
          rd_en      = 1'b1;
          rd_addr    = front_r;
          front_nxt  = front_inc;
          cnt_nxt    = cnt_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
        dq_pkg::REQ_POP_REAR: begin
          rd_en      = 1'b1;
          rd_addr    = rear_pop;
          cnt_nxt    = cnt_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= dq_pkg::req_t'(req_type);
      val_r <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.exec && rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      cnt_r    <= '0;
      stat_r   <= dq_pkg::ST_OK;
      pop_ok_r <= 1'b0;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      cnt_r    <= cnt_nxt;
      stat_r   <= stat_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  assign pop_value = pop_ok_r ? $signed(rd_r) : '0;
  assign status    = stat_r;
  assign entries   = cnt_r;

  `DQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "count above depth")
  `DQ_ASSERT_NEXT(a_cnt_hold, clk, rst_n, !cmd.exec, $stable(cnt_r) && $stable(front_r), "pointers moved without a request")
  `DQ_ASSERT_NEXT(a_overflow, clk, rst_n, cmd.exec && is_push && full, stat_r == dq_pkg::ST_OVERFLOW && $stable(cnt_r), "full push not dropped")
endmodule
`default_nettype wire

/* rtl/core/double_ended_queue.sv */
// double-ended queue top level: one result beat for each request beat
// an accepted request is executed and then offered as a result; a new request is accepted
// only after the result is taken, set by the latch/execute/result sequence
// around the ring store
// reset: synchronous active-low, empties the queue and sets the front pointer to zero
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dq_pkg::cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_type   (in_ch.req_type),
    .push_value (in_ch.push_value),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .entries    (out_ch.entries)
  );
endmodule
`default_nettype wire
